>>> rtl/core/wwml_pkg.sv
// ----------------------------------------------------------------------------
// wwml_pkg
// Shared constants, types and helpers for the whole-word match locator.
// ----------------------------------------------------------------------------
package wwml_pkg;

	localparam int MAX_WORD_LEN = 32;
	localparam int WINDOW       = MAX_WORD_LEN + 1;
	localparam int POS_BITS     = 16;
	localparam int LEN_W        = 6;
	localparam int WIN_IDX_W    = $clog2(WINDOW);
	localparam int WORD_IDX_W   = $clog2(MAX_WORD_LEN);
	localparam int COL_W        = POS_BITS + 1;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 64;
	localparam int NUM_WORD_REGS = 4;
	localparam int BYTES_PER_REG = CFG_DATA_W / 8;

	localparam logic [POS_BITS-1:0] POS_MAX = '1;
	localparam logic [COL_W-1:0]    COL_CAP = COL_W'({1'b0, POS_MAX}) + COL_W'(MAX_WORD_LEN);

	localparam logic [7:0] CHAR_NL         = 8'h0A;
	localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CHAR_HIGH_BIT   = 8'h80;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WORD0  = 3'd0,
		REG_WORD1  = 3'd1,
		REG_WORD2  = 3'd2,
		REG_WORD3  = 3'd3,
		REG_LENGTH = 3'd4
	} cfg_reg_t;

	typedef logic [MAX_WORD_LEN-1:0][7:0] word_vec_t;
	typedef logic [WINDOW-1:0][7:0]       window_t;

	// Word as seen from the history: exp[i] is the byte expected i places back
	typedef struct packed {
		logic             usable;
		logic [LEN_W-1:0] len;
		word_vec_t        exp;
	} cfg_info_t;

	typedef struct packed {
		window_t             recent;
		logic [LEN_W-1:0]    seen;
		logic [POS_BITS-1:0] line;
		logic [COL_W-1:0]    col;
	} hist_t;

	function automatic logic is_ident(input logic [7:0] c);
		logic r;
		r = ((c & CHAR_HIGH_BIT) != 8'h00) || (c == CHAR_UNDERSCORE) ||
			(c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
		return r;
	endfunction

endpackage

>>> rtl/core/whole_word_match_locator_unit.sv
// ----------------------------------------------------------------------------
// whole_word_match_locator_unit
// Streams document bytes and reports whole-word occurrences of a set word.
// ----------------------------------------------------------------------------
// Usage:
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0..3 load
//   word bytes 0-7 .. 24-31 (first byte low), index 4 loads the word length;
//   other indices are dropped. cfg_ready is always high; write only when idle.
//   Input channel (in_valid/in_stall): one text byte per beat, end_of_text on
//   the last byte of a document; the stream state then returns to zero.
//   Output channel (out_valid/out_stall): one beat per match with line, start
//   and end column. A match shows on the beat of the byte after the word, or
//   on the last byte if the word ends the text.
// Timing: a byte is held in the input register after the accepting edge and
//   its result is registered in the result register when the byte advances,
//   which a held result can delay. One byte per cycle is sustained while
//   out_stall is low; the window compare is combinational over 32 byte lanes.
// Stall: the input register keeps taking a byte while a result waits; in_stall
//   rises only when both the input register and the result register are full
//   and out_stall is high.
// Reset: arst_n clears the valid flags, the configuration registers, the history and the counters.
// ----------------------------------------------------------------------------
module whole_word_match_locator_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [wwml_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [wwml_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [7:0]                       text_byte,
	input  logic                             end_of_text,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [wwml_pkg::POS_BITS-1:0]    match_line,
	output logic [wwml_pkg::POS_BITS-1:0]    match_start_column,
	output logic [wwml_pkg::POS_BITS-1:0]    match_end_column
);
	import wwml_pkg::*;

	cfg_info_t  info;
	hist_t      hist;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eot_s1;
	logic       accept, advance;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign accept    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= text_byte;
			eot_s1  <= end_of_text;
		end
	end

	wwml_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.info      (info)
	);

	wwml_hist u_hist (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.text_byte   (byte_s1),
		.end_of_text (eot_s1),
		.hist        (hist)
	);

	wwml_match u_match (
		.clk                (clk),
		.arst_n             (arst_n),
		.advance            (advance),
		.text_byte          (byte_s1),
		.end_of_text        (eot_s1),
		.info               (info),
		.hist               (hist),
		.out_stall          (out_stall),
		.out_valid          (out_valid),
		.match_line         (match_line),
		.match_start_column (match_start_column),
		.match_end_column   (match_end_column)
	);

endmodule

>>> rtl/core/wwml_cfg.sv
// ----------------------------------------------------------------------------
// wwml_cfg
// Configuration registers and the word laid out against the byte history.
// ----------------------------------------------------------------------------
module wwml_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic [wwml_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [wwml_pkg::CFG_DATA_W-1:0]    cfg_data,
	output wwml_pkg::cfg_info_t                info
);
	import wwml_pkg::*;

	logic [NUM_WORD_REGS-1:0][CFG_DATA_W-1:0] word_q;
	logic [LEN_W-1:0]                         len_q;
	word_vec_t                                word_b;
	word_vec_t                                exp;
	logic                                     has_nl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
			len_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_WORD0:  word_q[0] <= cfg_data;
				REG_WORD1:  word_q[1] <= cfg_data;
				REG_WORD2:  word_q[2] <= cfg_data;
				REG_WORD3:  word_q[3] <= cfg_data;
				REG_LENGTH: len_q     <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		logic [LEN_W:0] idx;
		has_nl = 1'b0;
		for (int j = 0; j < MAX_WORD_LEN; j++) begin
			word_b[j] = word_q[j / BYTES_PER_REG][(j % BYTES_PER_REG)*8 +: 8];
		end
		for (int i = 0; i < MAX_WORD_LEN; i++) begin
			// byte i places back from the newest is word byte len-1-i
			idx = {1'b0, len_q} - (LEN_W+1)'(i) - (LEN_W+1)'(1);
			if ((LEN_W+1)'(i) < {1'b0, len_q}) begin
				exp[i] = word_b[idx[WORD_IDX_W-1:0]];
				if (word_b[i] == CHAR_NL)
					has_nl = 1'b1;
			end else begin
				exp[i] = 8'h00;
			end
		end
	end

	assign info.len    = len_q;
	assign info.exp    = exp;
	assign info.usable = (len_q != '0) && (len_q <= LEN_W'(MAX_WORD_LEN)) && !has_nl;

endmodule

>>> rtl/core/wwml_hist.sv
// ----------------------------------------------------------------------------
// wwml_hist
// Byte history window with line and column tracking.
// ----------------------------------------------------------------------------
module wwml_hist (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  logic [7:0]         text_byte,
	input  logic               end_of_text,
	output wwml_pkg::hist_t    hist
);
	import wwml_pkg::*;

	window_t             recent_q;
	logic [LEN_W-1:0]    seen_q;
	logic [POS_BITS-1:0] line_q;
	logic [COL_W-1:0]    col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q <= '0;
			seen_q   <= '0;
			line_q   <= '0;
			col_q    <= '0;
		end else if (advance) begin
			if (end_of_text) begin
				recent_q <= '0;
				seen_q   <= '0;
				line_q   <= '0;
				col_q    <= '0;
			end else begin
				recent_q <= {recent_q[WINDOW-2:0], text_byte};
				if (seen_q < LEN_W'(WINDOW))
					seen_q <= seen_q + LEN_W'(1);
				if (text_byte == CHAR_NL) begin
					if (line_q != POS_MAX)
						line_q <= line_q + POS_BITS'(1);
					col_q <= '0;
				end else if (col_q < COL_CAP) begin
					col_q <= col_q + COL_W'(1);
				end
			end
		end
	end

	assign hist.recent = recent_q;
	assign hist.seen   = seen_q;
	assign hist.line   = line_q;
	assign hist.col    = col_q;

endmodule

>>> rtl/core/wwml_match.sv
// ----------------------------------------------------------------------------
// wwml_match
// Parallel window compare, boundary checks and the result register.
// ----------------------------------------------------------------------------
module wwml_match (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            advance,
	input  logic [7:0]                      text_byte,
	input  logic                            end_of_text,
	input  wwml_pkg::cfg_info_t             info,
	input  wwml_pkg::hist_t                 hist,
	input  logic                            out_stall,
	output logic                            out_valid,
	output logic [wwml_pkg::POS_BITS-1:0]   match_line,
	output logic [wwml_pkg::POS_BITS-1:0]   match_start_column,
	output logic [wwml_pkg::POS_BITS-1:0]   match_end_column
);
	import wwml_pkg::*;

	logic                  eq_prev, eq_last;
	logic                  hit_prev, hit_last, found;
	logic [WIN_IDX_W-1:0]  idx_prev, idx_last;
	logic [LEN_W:0]        seen_p1;
	logic [COL_W-1:0]      start;
	logic [COL_W:0]        end_sum;
	logic [POS_BITS-1:0]   start_sat, end_sat;
	logic                  out_valid_q;
	logic [POS_BITS-1:0]   line_q, start_q, end_q;
	word_vec_t             last_win;

	// window including the incoming byte
	assign last_win = {hist.recent[MAX_WORD_LEN-2:0], text_byte};

	always_comb begin
		eq_prev = 1'b1;
		eq_last = 1'b1;
		for (int i = 0; i < MAX_WORD_LEN; i++) begin
			if (LEN_W'(i) < info.len) begin
				if (hist.recent[i] != info.exp[i])
					eq_prev = 1'b0;
				if (last_win[i] != info.exp[i])
					eq_last = 1'b0;
			end
		end
	end

	assign idx_prev = info.usable ? WIN_IDX_W'(info.len) : '0;
	assign idx_last = info.usable ? WIN_IDX_W'(info.len - LEN_W'(1)) : '0;
	assign seen_p1  = {1'b0, hist.seen} + (LEN_W+1)'(1);

	// word closed by a non-identifier byte
	assign hit_prev = info.usable && (hist.seen >= info.len) && !is_ident(text_byte) &&
		eq_prev && !((hist.seen > info.len) && is_ident(hist.recent[idx_prev]));

	// word that ends with the last byte of the text
	assign hit_last = info.usable && end_of_text && (seen_p1 >= {1'b0, info.len}) &&
		eq_last && !((seen_p1 > {1'b0, info.len}) && is_ident(hist.recent[idx_last]));

	assign found = hit_prev || hit_last;

	assign start = hit_prev ? hist.col - COL_W'(info.len)
	                        : hist.col - COL_W'(info.len) + COL_W'(1);
	assign end_sum   = {1'b0, start} + (COL_W+1)'(info.len);
	assign start_sat = (start > COL_W'(POS_MAX)) ? POS_MAX : start[POS_BITS-1:0];
	assign end_sat   = (end_sum > (COL_W+1)'(POS_MAX)) ? POS_MAX : end_sum[POS_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= found;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && found) begin
			line_q  <= hist.line;
			start_q <= start_sat;
			end_q   <= end_sat;
		end
	end

	assign out_valid          = out_valid_q;
	assign match_line         = line_q;
	assign match_start_column = start_q;
	assign match_end_column   = end_q;

endmodule

>>> rtl/core/wwml_checker.sv
// ----------------------------------------------------------------------------
// wwml_checker
// Port-level checks for the whole-word match locator, bound to the top level.
// ----------------------------------------------------------------------------
module wwml_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_stall,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [wwml_pkg::POS_BITS-1:0]   match_line,
	input logic [wwml_pkg::POS_BITS-1:0]   match_start_column,
	input logic [wwml_pkg::POS_BITS-1:0]   match_end_column
);
	import wwml_pkg::*;

	logic [POS_BITS:0] span;

	assign span = {1'b0, match_end_column} - {1'b0, match_start_column};

	// input side only backs up when the result beat is held
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("in_stall without a held result");

	// span is nonzero and at most the maximum word length unless the end column saturated
	a_span: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && match_end_column != POS_MAX) |->
			(span != '0 && span <= (POS_BITS+1)'(MAX_WORD_LEN)))
		else $error("match span outside word length");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (match_end_column >= match_start_column))
		else $error("end column before start column");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("result beat dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(match_line) &&
			$stable(match_start_column) && $stable(match_end_column)))
		else $error("result beat changed while stalled");

endmodule

bind whole_word_match_locator_unit wwml_checker u_wwml_checker (.*);

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the whole-word match locator. A short hand-written
// table covers boundaries, disabled lengths, dropped register indexes and the
// end-of-text cases. Random documents built from the configured word then run
// under three idle mixes. Every match beat is compared against an in-bench
// predictor or a typed-in value.
// ----------------------------------------------------------------------------
module tb;
	import wwml_pkg::*;

	localparam int DRAIN_CYCLES = 8;
	localparam int LIMIT_NS     = 10_000_000;
	localparam int MAX_REPORTS  = 10;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(REG_LENGTH) + 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = '1;

	typedef struct packed {
		logic [POS_BITS-1:0] line;
		logic [POS_BITS-1:0] start_col;
		logic [POS_BITS-1:0] end_col;
	} hit_t;

	typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_HIT} chk_t;
	typedef enum logic {ROW_CFG, ROW_TEXT} row_kind_t;

	typedef struct {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   idx;
		logic [CFG_DATA_W-1:0]  data;
		logic [7:0]             b;
		logic                   eot;
		chk_t                   chk;
		hit_t                   hit;
	} row_t;

	logic                  clk;
	logic                  arst_n             = 1'b0;
	logic                  cfg_valid          = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index          = '0;
	logic [CFG_DATA_W-1:0] cfg_data           = '0;
	logic                  in_valid           = 1'b0;
	logic                  in_stall;
	logic [7:0]            text_byte          = '0;
	logic                  end_of_text        = 1'b0;
	logic                  out_valid;
	logic                  out_stall          = 1'b0;
	logic [POS_BITS-1:0]   match_line;
	logic [POS_BITS-1:0]   match_start_column;
	logic [POS_BITS-1:0]   match_end_column;

	// sideband travelling with each text beat: how its result is checked
	chk_t row_check = CHK_MODEL;
	hit_t row_hit   = '0;

	whole_word_match_locator_unit dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.text_byte          (text_byte),
		.end_of_text        (end_of_text),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.match_line         (match_line),
		.match_start_column (match_start_column),
		.match_end_column   (match_end_column)
	);

	// predictor state
	logic [CFG_DATA_W-1:0] word_reg [NUM_WORD_REGS] = '{default: '0};
	logic [LEN_W-1:0]      word_len_reg = '0;
	logic [7:0]            recent [WINDOW] = '{default: '0};
	int                    seen_bytes = 0;
	logic [POS_BITS-1:0]   cur_line   = '0;
	int                    cur_col    = 0;

	hit_t awaited_matches [$];
	int   mismatch_count = 0;
	int   send_idle_pct  = 0;
	int   recv_idle_pct  = 0;

	row_t       rows [$];
	logic [7:0] doc_word [MAX_WORD_LEN];
	int         doc_word_len = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic ident_byte(logic [7:0] c);
		return c[7] || (c == CHAR_UNDERSCORE) || (c >= "0" && c <= "9") ||
			(c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic logic [7:0] word_byte(int j);
		if (j >= MAX_WORD_LEN)
			return '0;
		return word_reg[j / BYTES_PER_REG][(j % BYTES_PER_REG) * 8 +: 8];
	endfunction

	// Looks for the word closed by this byte, or ending on it at end of text,
	// then advances the history and the line/column counters.
	task automatic locate_word(input logic [7:0] b, input logic eot,
			output logic found, output hit_t h);
		int n;
		int j;
		int start;
		int stop;
		int pos_cap;
		logic ok;
		logic usable;
		n = int'(word_len_reg);
		pos_cap = int'(POS_MAX);
		found = 1'b0;
		start = 0;
		h = '0;
		usable = (n != 0) && (n <= MAX_WORD_LEN);
		for (j = 0; usable && j < n; j++)
			if (word_byte(j) == CHAR_NL)
				usable = 1'b0;
		if (usable) begin
			if (seen_bytes >= n) begin
				ok = !ident_byte(b);
				for (j = 0; j < n; j++)
					if (recent[n - 1 - j] != word_byte(j))
						ok = 1'b0;
				if (ok && seen_bytes > n && ident_byte(recent[n]))
					ok = 1'b0;
				if (ok) begin
					found = 1'b1;
					start = cur_col - n;
				end
			end
			if (!found && eot && seen_bytes + 1 >= n) begin
				ok = (b == word_byte(n - 1));
				for (j = 0; j + 1 < n; j++)
					if (recent[n - 2 - j] != word_byte(j))
						ok = 1'b0;
				if (ok && seen_bytes + 1 > n && ident_byte(recent[n - 1]))
					ok = 1'b0;
				if (ok) begin
					found = 1'b1;
					start = cur_col - (n - 1);
				end
			end
		end
		if (found) begin
			stop = start + n;
			h.line      = cur_line;
			h.start_col = POS_BITS'((start > pos_cap) ? pos_cap : start);
			h.end_col   = POS_BITS'((stop > pos_cap) ? pos_cap : stop);
		end
		if (eot) begin
			recent = '{default: '0};
			seen_bytes = 0;
			cur_line = '0;
			cur_col = 0;
		end else begin
			for (j = WINDOW - 1; j > 0; j--)
				recent[j] = recent[j - 1];
			recent[0] = b;
			if (seen_bytes < WINDOW)
				seen_bytes++;
			if (b == CHAR_NL) begin
				if (cur_line != POS_MAX)
					cur_line++;
				cur_col = 0;
			end else if (cur_col < int'(COL_CAP)) begin
				cur_col++;
			end
		end
	endtask

	// register shadow, prediction on each accepted text beat, match checking
	always @(posedge clk) begin : watch
		hit_t got;
		hit_t want;
		hit_t model_hit;
		logic model_found;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = '{match_line, match_start_column, match_end_column};
				if (awaited_matches.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("%0t: unexpected match beat line %0d start %0d end %0d",
							$realtime, got.line, got.start_col, got.end_col);
				end else begin
					want = awaited_matches.pop_front();
					if (got.line != want.line || got.start_col != want.start_col ||
							got.end_col != want.end_col) begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTS)
							$display("%0t: expected %0d/%0d/%0d, got %0d/%0d/%0d",
								$realtime, want.line, want.start_col, want.end_col,
								got.line, got.start_col, got.end_col);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index < NUM_WORD_REGS)
					word_reg[cfg_index[1:0]] = cfg_data;
				else if (cfg_index == REG_LENGTH)
					word_len_reg = cfg_data[LEN_W-1:0];
			end
			if (in_valid && !in_stall) begin
				locate_word(text_byte, end_of_text, model_found, model_hit);
				case (row_check)
					CHK_HIT: awaited_matches.insert(awaited_matches.size(), row_hit);
					CHK_MODEL: begin
						if (model_found)
							awaited_matches.insert(awaited_matches.size(), model_hit);
					end
					default: ;
				endcase
			end
		end
	end

	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_idle_pct);

	task automatic send_byte(input logic [7:0] b, input logic eot, input chk_t k,
			input hit_t h);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		text_byte   <= b;
		end_of_text <= eot;
		row_check   <= k;
		row_hit     <= h;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	// hold the sender off until every awaited match is back, then let the pipe drain
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited_matches.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		rows.insert(rows.size(), row_t'{ROW_CFG, idx, d, 8'h00, 1'b0, CHK_NONE, '0});
	endfunction

	function automatic void add_byte(logic [7:0] b, logic eot);
		rows.insert(rows.size(), row_t'{ROW_TEXT, '0, '0, b, eot, CHK_MODEL, '0});
	endfunction

	function automatic void add_none(logic [7:0] b, logic eot);
		rows.insert(rows.size(), row_t'{ROW_TEXT, '0, '0, b, eot, CHK_NONE, '0});
	endfunction

	function automatic void add_hit(logic [7:0] b, logic eot, int ln, int sc, int ec);
		rows.insert(rows.size(), row_t'{ROW_TEXT, '0, '0, b, eot, CHK_HIT,
			'{POS_BITS'(ln), POS_BITS'(sc), POS_BITS'(ec)}});
	endfunction

	function automatic logic [7:0] pick_sep();
		case ($urandom_range(7))
			0: return " ";
			1: return CHAR_NL;
			2: return "+";
			3: return ".";
			4: return 8'h00;
			5: return "\t";
			6: return "-";
			default: return ",";
		endcase
	endfunction

	function automatic logic [7:0] pick_ident();
		case ($urandom_range(5))
			0: return 8'("a" + $urandom_range(2));
			1: return 8'("A" + $urandom_range(25));
			2: return 8'("0" + $urandom_range(9));
			3: return CHAR_UNDERSCORE;
			4: return CHAR_HIGH_BIT | 8'($urandom_range(127));
			default: return 8'("a" + $urandom_range(25));
		endcase
	endfunction

	function automatic logic [7:0] pick_any();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return pick_ident();
		if (r < 80)
			return pick_sep();
		return 8'($urandom_range(255));
	endfunction

	task automatic new_word();
		logic [7:0] w [MAX_WORD_LEN];
		logic [CFG_DATA_W-1:0] d;
		int r;
		int len;
		int k;
		int fill;
		settle();
		r = $urandom_range(99);
		if (r < 10)
			len = MAX_WORD_LEN;
		else if (r < 14)
			len = 0;
		else if (r < 16)
			len = 2 ** LEN_W - 1;
		else if (r < 18)
			len = $urandom_range(MAX_WORD_LEN + 1, 2 ** LEN_W - 2);
		else if (r < 28)
			len = $urandom_range(5, MAX_WORD_LEN - 1);
		else
			len = $urandom_range(1, 4);
		fill = $urandom_range(19);
		for (k = 0; k < MAX_WORD_LEN; k++)
			w[k] = (fill == 0) ? 8'hFF : (fill == 1) ? 8'h00 : pick_any();
		for (r = 0; r < NUM_WORD_REGS; r++) begin
			for (k = 0; k < BYTES_PER_REG; k++)
				d[k * 8 +: 8] = w[r * BYTES_PER_REG + k];
			cfg_write(CFG_IDX_W'(r), d);
			if ($urandom_range(9) == 0)
				cfg_write(CFG_IDX_W'($urandom_range(int'(REG_SPARE_LO), int'(REG_SPARE_HI))),
					{$urandom, $urandom});
		end
		// junk above the length field must be dropped
		d = {$urandom, $urandom};
		d[LEN_W-1:0] = LEN_W'(len);
		cfg_write(REG_LENGTH, d);
		cfg_valid <= 1'b0;
		doc_word = w;
		doc_word_len = (len > MAX_WORD_LEN) ? MAX_WORD_LEN : len;
	endtask

	task automatic send_document(output int sent);
		logic [7:0] doc [$];
		int target;
		int t;
		int k;
		int cut;
		target = ($urandom_range(19) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 40);
		while (doc.size() < target) begin
			t = $urandom_range(99);
			if (t < 40) begin
				for (k = 0; k < doc_word_len; k++)
					doc.insert(doc.size(), doc_word[k]);
			end else if (t < 50 && doc_word_len > 1) begin
				cut = $urandom_range(1, doc_word_len - 1);
				for (k = 0; k < cut; k++)
					doc.insert(doc.size(), doc_word[k]);
			end else if (t < 65) begin
				doc.insert(doc.size(), pick_sep());
			end else if (t < 80) begin
				doc.insert(doc.size(), pick_ident());
			end else begin
				doc.insert(doc.size(), 8'($urandom_range(255)));
			end
		end
		for (k = 0; k < doc.size(); k++)
			send_byte(doc[k], k == doc.size() - 1, CHK_MODEL, '0);
		sent = doc.size();
	endtask

	task automatic random_run(input int budget);
		int done;
		int goal;
		int got;
		int n;
		done = 0;
		while (done < budget) begin
			new_word();
			goal = $urandom_range(40, 150);
			got = 0;
			while (got < goal) begin
				send_document(n);
				got += n;
			end
			done += got;
		end
	endtask

	initial begin
		#(LIMIT_NS);
		$display("FAILURE");
		$finish;
	end

	initial begin : main
		int i;

		// word "ab": match closed by a space, then one ending the text
		add_cfg(REG_WORD0, 64'h6261);
		add_cfg(REG_LENGTH, 64'd2);
		add_byte("a", 1'b0);
		add_byte("b", 1'b0);
		add_hit(" ", 1'b0, 0, 0, 2);
		add_byte("a", 1'b0);
		add_hit("b", 1'b1, 0, 3, 5);
		// non-identifier word: both checks hold on the last byte, earlier one wins
		add_cfg(REG_WORD0, 64'h2B);
		add_cfg(REG_LENGTH, 64'd1);
		add_byte("+", 1'b0);
		add_hit("+", 1'b1, 0, 0, 1);
		// lengths past the word limit disable matching
		add_cfg(REG_LENGTH, 64'd33);
		add_none("+", 1'b1);
		add_cfg(REG_LENGTH, 64'd63);
		add_none("+", 1'b1);
		// writes to spare indexes must not land anywhere
		add_cfg(REG_LENGTH, 64'd1);
		add_cfg(REG_SPARE_LO, '1);
		add_cfg(REG_SPARE_HI, '1);
		add_hit("+", 1'b1, 0, 0, 1);
		// a word holding a newline never matches
		add_cfg(REG_WORD0, 64'(CHAR_NL));
		add_byte(CHAR_NL, 1'b0);
		add_none(" ", 1'b1);
		// byte extremes: 0xff is an identifier, 0x00 is not
		add_cfg(REG_WORD0, 64'hFF);
		add_byte(8'h00, 1'b0);
		add_byte(8'hFF, 1'b0);
		add_hit(8'h00, 1'b1, 0, 1, 2);
		// second line, then an identifier right before the word
		add_cfg(REG_WORD0, 64'h6261);
		add_cfg(REG_LENGTH, 64'd2);
		add_byte(CHAR_NL, 1'b0);
		add_byte("a", 1'b0);
		add_hit("b", 1'b1, 1, 0, 2);
		add_byte("x", 1'b0);
		add_byte("a", 1'b0);
		add_byte("b", 1'b0);
		add_none(" ", 1'b1);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 33;
		recv_idle_pct = 59;
		for (i = 0; i < rows.size(); i++) begin
			if (rows[i].kind == ROW_CFG) begin
				if (i == 0 || rows[i - 1].kind != ROW_CFG)
					settle();
				cfg_write(rows[i].idx, rows[i].data);
				if (i + 1 == rows.size() || rows[i + 1].kind != ROW_CFG)
					cfg_valid <= 1'b0;
			end else begin
				send_byte(rows[i].b, rows[i].eot, rows[i].chk, rows[i].hit);
			end
		end
		random_run(450);

		send_idle_pct = 59;
		recv_idle_pct = 33;
		random_run(450);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_run(450);

		settle();
		if (mismatch_count == 0 && awaited_matches.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
